FILE: src/bmp24_pkg.sv
// shared types and constants for the 24-bit bmp stream decoder
package bmp24_pkg;

  // default limit on image width and height
  localparam int MAX_DIM_DEFAULT = 4096;

  // captured dimension: low 17 bits of the header field, upper bits kept as a flag
  localparam int DIM_W = 17;
  // compare width for counter increments against a dimension
  localparam int EXT_W = DIM_W + 1;

  // file layout
  localparam logic [7:0] SIG_B       = 8'h42;
  localparam logic [7:0] SIG_M       = 8'h4D;
  localparam logic [5:0] INFO_START  = 6'd14;
  localparam logic [5:0] HEADER_LAST = 6'd53;
  localparam logic [7:0] INFO_SIZE   = 8'd40;
  localparam logic [7:0] BITS_PER_PX = 8'd24;
  localparam logic [7:0] PLANES      = 8'd1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_SIGNATURE = 2'd0,
    ERR_FORMAT    = 2'd1,
    ERR_NOT_GRAY  = 2'd2
  } err_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    err_t        error_code;
    logic        last_pixel;
  } result_t;

endpackage

FILE: src/bmp24_parse.sv
// header parser and pixel assembler: parse state and per-byte result logic
module bmp24_parse import bmp24_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       mono_mode,
  output logic       res_valid,
  output result_t    res
);

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  // header byte positions
  localparam logic [5:0] POS_SIG_B  = 6'd0;
  localparam logic [5:0] POS_SIG_M  = 6'd1;
  localparam logic [5:0] POS_HSIZE  = INFO_START;
  localparam logic [5:0] POS_HSIZE3 = INFO_START + 6'd3;
  localparam logic [5:0] POS_W0     = INFO_START + 6'd4;
  localparam logic [5:0] POS_W1     = INFO_START + 6'd5;
  localparam logic [5:0] POS_W2     = INFO_START + 6'd6;
  localparam logic [5:0] POS_W3     = INFO_START + 6'd7;
  localparam logic [5:0] POS_H0     = INFO_START + 6'd8;
  localparam logic [5:0] POS_H1     = INFO_START + 6'd9;
  localparam logic [5:0] POS_H2     = INFO_START + 6'd10;
  localparam logic [5:0] POS_H3     = INFO_START + 6'd11;
  localparam logic [5:0] POS_PLANES = INFO_START + 6'd12;
  localparam logic [5:0] POS_PLANE1 = INFO_START + 6'd13;
  localparam logic [5:0] POS_BPP    = INFO_START + 6'd14;
  localparam logic [5:0] POS_ZERO0  = INFO_START + 6'd15;
  localparam logic [5:0] POS_ZERO1  = INFO_START + 6'd23;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_PIXELS = 3'b010,
    PH_IDLE   = 3'b100
  } phase_t;

  // parse state
  phase_t             phase, phase_next;
  logic [5:0]         header_position, header_position_next;
  logic               format_bad, format_bad_next;
  logic [DIM_W-1:0]   width_seen, width_seen_next;
  logic [DIM_W-1:0]   height_seen, height_seen_next;
  logic               width_big, width_big_next;
  logic               height_big, height_big_next;
  logic [CNT_W-1:0]   column_count, column_count_next;
  logic [CNT_W-1:0]   row_count, row_count_next;
  logic [1:0]         byte_in_pixel, byte_in_pixel_next;
  logic [1:0]         pad_left, pad_left_next;
  logic [7:0]         held_blue, held_blue_next;
  logic [7:0]         held_green, held_green_next;

  // effective state once a first-byte restart is applied
  phase_t             ph;
  logic [5:0]         pos;
  logic               fbad;
  logic               info_bad;
  logic               too_big;
  logic [EXT_W-1:0]   col_inc;
  logic [EXT_W-1:0]   row_inc;
  logic               at_last;

  // next state and result for the byte in the input register
  always_comb begin
    ph   = first_byte ? PH_HEADER : phase;
    pos  = first_byte ? 6'd0 : header_position;
    fbad = first_byte ? 1'b0 : format_bad;

    phase_next           = ph;
    header_position_next = pos;
    format_bad_next      = fbad;
    width_seen_next      = width_seen;
    height_seen_next     = height_seen;
    width_big_next       = width_big;
    height_big_next      = height_big;
    column_count_next    = column_count;
    row_count_next       = row_count;
    byte_in_pixel_next   = byte_in_pixel;
    pad_left_next        = pad_left;
    held_blue_next       = held_blue;
    held_green_next      = held_green;

    res_valid = 1'b0;
    res       = '0;

    // fixed fields of the info header
    case (pos) inside
      POS_HSIZE:                                 info_bad = (data_byte != INFO_SIZE);
      [POS_HSIZE + 6'd1:POS_HSIZE3], POS_PLANE1,
      [POS_ZERO0:POS_ZERO1]:                     info_bad = (data_byte != 8'd0);
      POS_PLANES:                                info_bad = (data_byte != PLANES);
      POS_BPP:                                   info_bad = (data_byte != BITS_PER_PX);
      default:                                   info_bad = 1'b0;
    endcase

    too_big = width_big || height_big ||
              (width_seen > DIM_W'(MAX_DIM)) || (height_seen > DIM_W'(MAX_DIM));

    col_inc = EXT_W'(column_count) + EXT_W'(1);
    row_inc = EXT_W'(row_count) + EXT_W'(1);
    at_last = (col_inc == EXT_W'(width_seen)) && (row_inc == EXT_W'(height_seen));

    case (ph)
      PH_HEADER: begin
        if ((pos == POS_SIG_B && data_byte != SIG_B) ||
            (pos == POS_SIG_M && data_byte != SIG_M)) begin
          res_valid        = 1'b1;
          res.kind         = KIND_ERROR;
          res.error_code   = ERR_SIGNATURE;
          phase_next       = PH_IDLE;
        end else begin
          format_bad_next = fbad | info_bad;
          // dimension capture, little endian
          case (pos)
            POS_W0: width_seen_next[7:0]  = data_byte;
            POS_W1: width_seen_next[15:8] = data_byte;
            POS_W2: begin
              width_seen_next[DIM_W-1] = data_byte[0];
              width_big_next           = |data_byte[7:1];
            end
            POS_W3: width_big_next = width_big | (|data_byte);
            POS_H0: height_seen_next[7:0]  = data_byte;
            POS_H1: height_seen_next[15:8] = data_byte;
            POS_H2: begin
              height_seen_next[DIM_W-1] = data_byte[0];
              height_big_next           = |data_byte[7:1];
            end
            POS_H3: height_big_next = height_big | (|data_byte);
            default: ;
          endcase
          if (pos < HEADER_LAST) begin
            header_position_next = pos + 6'd1;
          end else if (fbad || too_big) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_FORMAT;
            phase_next     = PH_IDLE;
          end else begin
            res_valid          = 1'b1;
            res.kind           = KIND_HEADER;
            res.image_width    = 13'(width_seen);
            res.image_height   = 13'(height_seen);
            column_count_next  = '0;
            row_count_next     = '0;
            byte_in_pixel_next = 2'd0;
            pad_left_next      = 2'd0;
            phase_next = (width_seen == '0 || height_seen == '0) ? PH_IDLE : PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        if (pad_left != 2'd0) begin
          // row padding
          pad_left_next = pad_left - 2'd1;
          if (pad_left == 2'd1) begin
            column_count_next = '0;
            row_count_next    = CNT_W'(row_inc);
            if (row_inc >= EXT_W'(height_seen)) begin
              phase_next = PH_IDLE;
            end
          end
        end else if (byte_in_pixel == 2'd0) begin
          held_blue_next     = data_byte;
          byte_in_pixel_next = 2'd1;
        end else if (byte_in_pixel == 2'd1) begin
          held_green_next    = data_byte;
          byte_in_pixel_next = 2'd2;
        end else begin
          byte_in_pixel_next = 2'd0;
          if (mono_mode && (data_byte != held_green || held_green != held_blue)) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NOT_GRAY;
            phase_next     = PH_IDLE;
          end else begin
            res_valid      = 1'b1;
            res.kind       = KIND_PIXEL;
            res.red        = data_byte;
            res.green      = held_green;
            res.blue       = held_blue;
            res.column     = 12'(column_count);
            res.row        = 12'(row_count);
            res.last_pixel = at_last;
            if (at_last) begin
              phase_next = PH_IDLE;
            end else begin
              column_count_next = CNT_W'(col_inc);
              // end of row: skip padding or move to the next row
              if (col_inc >= EXT_W'(width_seen)) begin
                pad_left_next = width_seen[1:0];
                if (width_seen[1:0] == 2'd0) begin
                  column_count_next = '0;
                  row_count_next    = CNT_W'(row_inc);
                  if (row_inc >= EXT_W'(height_seen)) begin
                    phase_next = PH_IDLE;
                  end
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_position <= 6'd0;
      format_bad      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      format_bad      <= format_bad_next;
    end
  end

  // captured header fields and pixel assembly
  always_ff @(posedge clk) begin
    if (step) begin
      width_seen    <= width_seen_next;
      height_seen   <= height_seen_next;
      width_big     <= width_big_next;
      height_big    <= height_big_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      byte_in_pixel <= byte_in_pixel_next;
      pad_left      <= pad_left_next;
      held_blue     <= held_blue_next;
      held_green    <= held_green_next;
    end
  end

endmodule

FILE: src/bmp24_stream_decoder_core.sv
// top level of the 24-bit bmp stream decoder: input register, parser, result register
// a byte passes from the input register through the parser into the result register
// throughput: one byte per cycle while the result side does not stall
// a byte waits in the input register only while a result is held and stalled
// reset clears the valid flags, the mono mode register and the parser to the
// start of a file; parsing after reset begins at byte 0 without a first flag
module bmp24_stream_decoder_core import bmp24_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        mono_mode_write,
  input  logic        mono_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic [12:0] image_width,
  output logic [12:0] image_height,
  output logic [1:0]  error_code,
  output logic        last_pixel
);

  logic       mono_reg;
  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_first;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_reg;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      mono_reg <= 1'b0;
    end else if (mono_mode_write) begin
      mono_reg <= mono_mode;
    end
  end

  // the held byte moves on when the result register is free or being emptied
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte  <= data_byte;
      in_reg_first <= first_byte;
    end
  end

  bmp24_parse #(
    .MAX_DIM(MAX_DIM)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_reg_byte),
    .first_byte (in_reg_first),
    .mono_mode  (mono_reg),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_reg <= res;
    end
  end

  // result item fields
  assign kind         = out_reg.kind;
  assign red          = out_reg.red;
  assign green        = out_reg.green;
  assign blue         = out_reg.blue;
  assign column       = out_reg.column;
  assign row          = out_reg.row;
  assign image_width  = out_reg.image_width;
  assign image_height = out_reg.image_height;
  assign error_code   = out_reg.error_code;
  assign last_pixel   = out_reg.last_pixel;

endmodule
